### rtl/spbs_pkg.sv
package spbs_pkg;

  // Coordinate format: signed Q16.8.
  localparam int CW = 24;
  // Smoothing factor: unsigned Q2.14.
  localparam int SMOOTH_W = 16;
  localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 16'd16384;

  // Offset datapath widths.
  localparam int PROD_W = CW + SMOOTH_W;
  localparam int X_W    = PROD_W + 1 - 14;
  localparam int Q_W    = CW + 1;
  localparam int OFF_W  = CW + 2;
  localparam int SUM_W  = CW + 3;

  // Rounding terms: half of 3*2^14 and of 6*2^14.
  localparam logic [PROD_W:0] HALF3 = (PROD_W+1)'(3 * (1 << 13));
  localparam logic [PROD_W:0] HALF6 = (PROD_W+1)'(3 * (1 << 14));
  // ceil(2^33 / 3): exact division by three for values below 2^32.
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
  localparam int RECIP3_SHIFT = 33;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (CW - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_CURVE = 2'd2
  } cmd_t;

  // What one accepted item produces.
  typedef enum logic [1:0] {
    PLAN_MOVE,
    PLAN_LINE,
    PLAN_CURVE,
    PLAN_TWO
  } plan_t;

  typedef struct packed {
    plan_t                 plan;
    logic                  last;
    logic                  div_a6;
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic signed [CW-1:0]  bx;
    logic signed [CW-1:0]  by;
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
    logic                  neg_ax;
    logic                  neg_ay;
    logic                  neg_bx;
    logic                  neg_by;
    logic                  neg_cx;
    logic                  neg_cy;
  } info_t;

  typedef struct packed {
    cmd_t                  command;
    logic signed [CW-1:0]  ctrl1_x;
    logic signed [CW-1:0]  ctrl1_y;
    logic signed [CW-1:0]  ctrl2_x;
    logic signed [CW-1:0]  ctrl2_y;
    logic signed [CW-1:0]  end_x;
    logic signed [CW-1:0]  end_y;
    logic                  path_end;
  } res_t;

  // Clamp a widened sum to the coordinate range.
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[CW-1:0];
  endfunction

endpackage

### rtl/spbs_offset_lane.sv
module spbs_offset_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [spbs_pkg::CW-1:0]       mag,
  input  logic [spbs_pkg::SMOOTH_W-1:0] smoothing,
  input  logic                          div6,
  output logic [spbs_pkg::Q_W-1:0]      q
);
  import spbs_pkg::*;

  logic [PROD_W-1:0]    prod_r;
  logic                 div6_r;
  logic [PROD_W:0]      sum_nxt;
  logic [X_W-1:0]       x_nxt;
  logic [X_W-1:0]       x_r;
  logic [X_W+31:0]      full_nxt;
  logic [Q_W-1:0]       q_r;

  // Add the rounding half and drop the power-of-two part of the divisor.
  always_comb begin
    sum_nxt = {1'b0, prod_r} + (div6_r ? HALF6 : HALF3);
    if (div6_r) begin
      x_nxt = {1'b0, sum_nxt[PROD_W:15]};
    end else begin
      x_nxt = sum_nxt[PROD_W:14];
    end
  end

  // The remaining division by three is a multiply by the reciprocal.
  assign full_nxt = (X_W+32)'(x_r) * (X_W+32)'(RECIP3);

  // Three stages: magnitude times smoothing, scaled value, quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(mag) * PROD_W'(smoothing);
      div6_r <= div6;
      x_r    <= x_nxt;
      q_r    <= full_nxt[RECIP3_SHIFT +: Q_W];
    end
  end

  assign q = q_r;

endmodule

### rtl/stroke_points_to_bezier_segments_top.sv
// Stroke points to cubic Bezier path commands.
// Input channel: in_point_x, in_point_y (signed Q16.8) and in_stroke_end, taken
// at an edge where in_valid is high and in_stall is low. Output channel: the path
// commands of each item (move, line or cubic curve with two control points),
// taken where out_valid is high and out_stall is low.
// The smoothing factor (unsigned Q2.14) is written through cfg_valid/cfg_ready
// and cfg_smoothing; cfg_ready is always high. Write it only while idle.
// Throughput: one point per cycle while out_stall is low. The last point of a
// stroke of three or more points gives two curves; the second is shown in the
// cycle after the first is taken, and the intake pauses until the second is
// taken. The rate is set by the five-register pipeline (differences, product,
// scaled value, quotient, result) that every point passes through without
// iteration.
// When out_stall is high while a result is shown, the whole pipeline holds and
// in_stall rises, so no item is lost. Reset (rst_n low, synchronous) empties the
// pipeline, clears the point window and count, and sets smoothing to 1.0.
module stroke_points_to_bezier_segments_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [spbs_pkg::CW-1:0]       in_point_x,
  input  logic signed [spbs_pkg::CW-1:0]       in_point_y,
  input  logic                                 in_stroke_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_command,
  output logic signed [spbs_pkg::CW-1:0]       out_ctrl1_x,
  output logic signed [spbs_pkg::CW-1:0]       out_ctrl1_y,
  output logic signed [spbs_pkg::CW-1:0]       out_ctrl2_x,
  output logic signed [spbs_pkg::CW-1:0]       out_ctrl2_y,
  output logic signed [spbs_pkg::CW-1:0]       out_end_x,
  output logic signed [spbs_pkg::CW-1:0]       out_end_y,
  output logic                                 out_path_end,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [spbs_pkg::SMOOTH_W-1:0]        cfg_smoothing
);
  import spbs_pkg::*;

  logic [SMOOTH_W-1:0]  smoothing_r;
  logic signed [CW-1:0] w0x_r, w0y_r, w1x_r, w1y_r, w2x_r, w2y_r;
  logic [1:0]           seen_r;
  logic [1:0]           seen_nxt;

  logic                 adv;
  logic                 accept;

  info_t                info_nxt;
  info_t                info1_r, info2_r, info3_r, info4_r;
  logic [4:1]           v_r;
  logic                 v1_nxt;
  logic [CW-1:0]        mag_ax_nxt, mag_ay_nxt, mag_bx_nxt, mag_by_nxt;
  logic [CW-1:0]        mag_cx_nxt, mag_cy_nxt;
  logic [CW-1:0]        mag_ax_r, mag_ay_r, mag_bx_r, mag_by_r, mag_cx_r, mag_cy_r;
  logic [Q_W-1:0]       q_ax, q_ay, q_bx, q_by, q_cx, q_cy;

  res_t                 res0_nxt, res1_nxt;
  res_t                 res0_r, res1_r, res_out;
  logic                 out_valid_r;
  logic                 two_r;
  logic                 second_r;

  // Configuration port.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothing_r <= SMOOTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      smoothing_r <= cfg_smoothing;
    end
  end

  // The pipeline moves whenever the result register is free or its last result is being taken.
  assign adv      = !out_valid_r || (!out_stall && (!two_r || second_r));
  assign in_stall = !adv;
  assign accept   = in_valid && !in_stall;

  // Signed difference to sign bit and magnitude.
  function automatic logic [CW:0] diff_mag(input logic signed [CW-1:0] p,
                                           input logic signed [CW-1:0] m);
    logic signed [CW:0] d;
    logic signed [CW:0] a;
    d = (CW+1)'(p) - (CW+1)'(m);
    a = d[CW] ? -d : d;
    return {d[CW], a[CW-1:0]};
  endfunction

  // Segment selection and neighbor differences from the point window.
  always_comb begin
    logic [CW:0] dax, day, dbx, dby, dcx, dcy;
    info_nxt    = '0;
    info_nxt.px = in_point_x;
    info_nxt.py = in_point_y;
    info_nxt.last = in_stroke_end;
    if (seen_r == 2'd3) begin
      info_nxt.ax     = w1x_r;
      info_nxt.ay     = w1y_r;
      info_nxt.bx     = w2x_r;
      info_nxt.by     = w2y_r;
      info_nxt.div_a6 = 1'b1;
      dax = diff_mag(w2x_r, w0x_r);
      day = diff_mag(w2y_r, w0y_r);
      dbx = diff_mag(in_point_x, w1x_r);
      dby = diff_mag(in_point_y, w1y_r);
      dcx = diff_mag(in_point_x, w2x_r);
      dcy = diff_mag(in_point_y, w2y_r);
    end else begin
      info_nxt.ax     = w0x_r;
      info_nxt.ay     = w0y_r;
      info_nxt.bx     = w1x_r;
      info_nxt.by     = w1y_r;
      info_nxt.div_a6 = 1'b0;
      dax = diff_mag(w1x_r, w0x_r);
      day = diff_mag(w1y_r, w0y_r);
      dbx = diff_mag(in_point_x, w0x_r);
      dby = diff_mag(in_point_y, w0y_r);
      dcx = diff_mag(in_point_x, w1x_r);
      dcy = diff_mag(in_point_y, w1y_r);
    end
    info_nxt.neg_ax = dax[CW];
    info_nxt.neg_ay = day[CW];
    info_nxt.neg_bx = dbx[CW];
    info_nxt.neg_by = dby[CW];
    info_nxt.neg_cx = dcx[CW];
    info_nxt.neg_cy = dcy[CW];
    mag_ax_nxt = dax[CW-1:0];
    mag_ay_nxt = day[CW-1:0];
    mag_bx_nxt = dbx[CW-1:0];
    mag_by_nxt = dby[CW-1:0];
    mag_cx_nxt = dcx[CW-1:0];
    mag_cy_nxt = dcy[CW-1:0];

    v1_nxt   = accept;
    seen_nxt = seen_r;
    case (seen_r)
      2'd0: begin
        info_nxt.plan = PLAN_MOVE;
        seen_nxt      = 2'd1;
      end
      2'd1: begin
        info_nxt.plan = PLAN_LINE;
        // A second point that does not end the stroke waits for the third.
        v1_nxt        = accept && in_stroke_end;
        seen_nxt      = 2'd2;
      end
      default: begin
        info_nxt.plan = in_stroke_end ? PLAN_TWO : PLAN_CURVE;
        seen_nxt      = 2'd3;
      end
    endcase
    if (in_stroke_end) begin
      seen_nxt = 2'd0;
    end
  end

  // Point window and count, updated per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
      w0x_r  <= '0;
      w0y_r  <= '0;
      w1x_r  <= '0;
      w1y_r  <= '0;
      w2x_r  <= '0;
      w2y_r  <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
      if (!in_stroke_end || seen_r == 2'd0) begin
        case (seen_r)
          2'd0: begin
            w0x_r <= in_point_x;
            w0y_r <= in_point_y;
          end
          2'd1: begin
            w1x_r <= in_point_x;
            w1y_r <= in_point_y;
          end
          2'd2: begin
            w2x_r <= in_point_x;
            w2y_r <= in_point_y;
          end
          default: begin
            w0x_r <= w1x_r;
            w0y_r <= w1y_r;
            w1x_r <= w2x_r;
            w1y_r <= w2y_r;
            w2x_r <= in_point_x;
            w2y_r <= in_point_y;
          end
        endcase
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:1], v1_nxt};
    end
  end

  // Item information travels beside the offset lanes.
  always_ff @(posedge clk) begin
    if (adv) begin
      info1_r  <= info_nxt;
      info2_r  <= info1_r;
      info3_r  <= info2_r;
      info4_r  <= info3_r;
      mag_ax_r <= mag_ax_nxt;
      mag_ay_r <= mag_ay_nxt;
      mag_bx_r <= mag_bx_nxt;
      mag_by_r <= mag_by_nxt;
      mag_cx_r <= mag_cx_nxt;
      mag_cy_r <= mag_cy_nxt;
    end
  end

  // Six offset lanes: segment start (first-segment chord or middle tangent), shared middle tangent, stroke end.
  spbs_offset_lane u_lane_ax (.clk(clk), .en(adv), .mag(mag_ax_r), .smoothing(smoothing_r),
                              .div6(info1_r.div_a6), .q(q_ax));
  spbs_offset_lane u_lane_ay (.clk(clk), .en(adv), .mag(mag_ay_r), .smoothing(smoothing_r),
                              .div6(info1_r.div_a6), .q(q_ay));
  spbs_offset_lane u_lane_bx (.clk(clk), .en(adv), .mag(mag_bx_r), .smoothing(smoothing_r),
                              .div6(1'b1), .q(q_bx));
  spbs_offset_lane u_lane_by (.clk(clk), .en(adv), .mag(mag_by_r), .smoothing(smoothing_r),
                              .div6(1'b1), .q(q_by));
  spbs_offset_lane u_lane_cx (.clk(clk), .en(adv), .mag(mag_cx_r), .smoothing(smoothing_r),
                              .div6(1'b0), .q(q_cx));
  spbs_offset_lane u_lane_cy (.clk(clk), .en(adv), .mag(mag_cy_r), .smoothing(smoothing_r),
                              .div6(1'b0), .q(q_cy));

  // Apply signs to the quotients.
  function automatic logic signed [OFF_W-1:0] signed_off(input logic [Q_W-1:0] q,
                                                         input logic neg);
    logic signed [OFF_W-1:0] m;
    m = $signed({1'b0, q});
    return neg ? -m : m;
  endfunction

  // Base point plus or minus an offset, clamped.
  function automatic logic signed [CW-1:0] ctrl_pt(input logic signed [CW-1:0] base,
                                                   input logic signed [OFF_W-1:0] off,
                                                   input logic sub);
    logic signed [SUM_W-1:0] s;
    if (sub) begin
      s = SUM_W'(base) - SUM_W'(off);
    end else begin
      s = SUM_W'(base) + SUM_W'(off);
    end
    return sat_coord(s);
  endfunction

  // Build the one or two results of the item at the end of the pipeline.
  always_comb begin
    logic signed [OFF_W-1:0] oax, oay, obx, oby, ocx, ocy;
    oax = signed_off(q_ax, info4_r.neg_ax);
    oay = signed_off(q_ay, info4_r.neg_ay);
    obx = signed_off(q_bx, info4_r.neg_bx);
    oby = signed_off(q_by, info4_r.neg_by);
    ocx = signed_off(q_cx, info4_r.neg_cx);
    ocy = signed_off(q_cy, info4_r.neg_cy);

    res0_nxt       = '0;
    res0_nxt.end_x = info4_r.px;
    res0_nxt.end_y = info4_r.py;
    case (info4_r.plan)
      PLAN_MOVE: begin
        res0_nxt.command  = CMD_MOVE;
        res0_nxt.path_end = info4_r.last;
      end
      PLAN_LINE: begin
        res0_nxt.command  = CMD_LINE;
        res0_nxt.path_end = 1'b1;
      end
      default: begin
        res0_nxt.command  = CMD_CURVE;
        res0_nxt.ctrl1_x  = ctrl_pt(info4_r.ax, oax, 1'b0);
        res0_nxt.ctrl1_y  = ctrl_pt(info4_r.ay, oay, 1'b0);
        res0_nxt.ctrl2_x  = ctrl_pt(info4_r.bx, obx, 1'b1);
        res0_nxt.ctrl2_y  = ctrl_pt(info4_r.by, oby, 1'b1);
        res0_nxt.end_x    = info4_r.bx;
        res0_nxt.end_y    = info4_r.by;
        res0_nxt.path_end = 1'b0;
      end
    endcase

    // Closing segment of a stroke.
    res1_nxt.command  = CMD_CURVE;
    res1_nxt.ctrl1_x  = ctrl_pt(info4_r.bx, obx, 1'b0);
    res1_nxt.ctrl1_y  = ctrl_pt(info4_r.by, oby, 1'b0);
    res1_nxt.ctrl2_x  = ctrl_pt(info4_r.px, ocx, 1'b1);
    res1_nxt.ctrl2_y  = ctrl_pt(info4_r.py, ocy, 1'b1);
    res1_nxt.end_x    = info4_r.px;
    res1_nxt.end_y    = info4_r.py;
    res1_nxt.path_end = 1'b1;
  end

  // Result register control: a two-result item shows its second one after
  // the first is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      two_r       <= 1'b0;
      second_r    <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[4];
      two_r       <= v_r[4] && (info4_r.plan == PLAN_TWO);
      second_r    <= 1'b0;
    end else if (!out_stall) begin
      second_r    <= 1'b1;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      res0_r <= res0_nxt;
      res1_r <= res1_nxt;
    end
  end

  assign res_out      = second_r ? res1_r : res0_r;
  assign out_valid    = out_valid_r;
  assign out_command  = res_out.command;
  assign out_ctrl1_x  = res_out.ctrl1_x;
  assign out_ctrl1_y  = res_out.ctrl1_y;
  assign out_ctrl2_x  = res_out.ctrl2_x;
  assign out_ctrl2_y  = res_out.ctrl2_y;
  assign out_end_x    = res_out.end_x;
  assign out_end_y    = res_out.end_y;
  assign out_path_end = res_out.path_end;

endmodule

### sim/tb_stroke_points_to_bezier_segments_top.sv
`timescale 1ns / 1ps

module tb_stroke_points_to_bezier_segments_top;
  import spbs_pkg::*;

  localparam int          ITEMS_PER_PHASE = 230;
  localparam int          DIRECTED_ROWS   = 20;
  localparam int          DRAIN_CYCLES    = 12;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int          TAU_DIV         = 6;
  localparam int          END_TAU_DIV     = 3;
  localparam longint      Q14_ONE         = 16384;
  localparam int          MAX_REPORTS     = 10;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [SMOOTH_W-1:0]  smooth_t;

  localparam coord_t COORD_MAX = coord_t'((1 << (CW - 1)) - 1);
  localparam coord_t COORD_MIN = coord_t'(1 << (CW - 1));

  // One stroke point, with its path command typed in where it is obvious.
  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
    bit     typed;
    bit     has_cmd;
    res_t   cmd;
  } point_row_t;

  logic    clk           = 1'b0;
  logic    rst_n         = 1'b0;
  logic    in_valid      = 1'b0;
  logic    in_stall;
  coord_t  in_point_x    = '0;
  coord_t  in_point_y    = '0;
  logic    in_stroke_end = 1'b0;
  logic    out_valid;
  logic    out_stall     = 1'b0;
  logic [1:0] out_command;
  coord_t  out_ctrl1_x, out_ctrl1_y, out_ctrl2_x, out_ctrl2_y, out_end_x, out_end_y;
  logic    out_path_end;
  logic    cfg_valid     = 1'b0;
  logic    cfg_ready;
  smooth_t cfg_smoothing = '0;

  // Predictor state: the point window, its fill count and the smoothing factor.
  longint  win_x [3];
  longint  win_y [3];
  int      points_held;
  longint  smooth_q14;

  res_t        path_cmd_q [$];
  int          mismatch_count = 0;
  int          result_count   = 0;
  int          stall_left     = 0;
  bit          sender_calm    = 1'b0;
  bit          receiver_calm  = 1'b0;
  int unsigned cycle_count    = 0;

  stroke_points_to_bezier_segments_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_stroke_end (in_stroke_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_command   (out_command),
    .out_ctrl1_x   (out_ctrl1_x),
    .out_ctrl1_y   (out_ctrl1_y),
    .out_ctrl2_x   (out_ctrl2_x),
    .out_ctrl2_y   (out_ctrl2_y),
    .out_end_x     (out_end_x),
    .out_end_y     (out_end_y),
    .out_path_end  (out_path_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_smoothing (cfg_smoothing)
  );

  always #5 clk = ~clk;

  // Control offset: diff * smoothing / (divisor * 1.0), rounded half away from zero.
  function automatic longint scaled_offset(input longint diff, input int divisor);
    longint d, mag, q;
    d   = divisor * Q14_ONE;
    mag = (diff < 0) ? -diff : diff;
    q   = (mag * smooth_q14 + d / 2) / d;
    return (diff < 0) ? -q : q;
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic res_t plain_cmd(input cmd_t op, input coord_t x, input coord_t y,
                                     input logic last);
    res_t r;
    r          = '0;
    r.command  = op;
    r.end_x    = x;
    r.end_y    = y;
    r.path_end = last;
    return r;
  endfunction

  // Curve from a to b: the in-tangent leaves a, the out-tangent arrives at b.
  function automatic res_t curve_cmd(input longint bx, by, ax, ay,
                                     input longint dix, diy, input int div_in,
                                     input longint dox, doy, input int div_out,
                                     input logic last);
    res_t r;
    r.command  = CMD_CURVE;
    r.ctrl1_x  = clamp_coord(ax + scaled_offset(dix, div_in));
    r.ctrl1_y  = clamp_coord(ay + scaled_offset(diy, div_in));
    r.ctrl2_x  = clamp_coord(bx - scaled_offset(dox, div_out));
    r.ctrl2_y  = clamp_coord(by - scaled_offset(doy, div_out));
    r.end_x    = coord_t'(bx);
    r.end_y    = coord_t'(by);
    r.path_end = last;
    return r;
  endfunction

  // Advance the point window by one stroke point and return the commands it completes.
  function automatic int trace_point(input coord_t px, input coord_t py, input logic last,
                                     output res_t seg_a, output res_t seg_b);
    longint x, y;
    int     n;
    x     = px;
    y     = py;
    n     = 1;
    seg_a = '0;
    seg_b = '0;
    case (points_held)
      0: begin
        seg_a       = plain_cmd(CMD_MOVE, px, py, last);
        win_x[0]    = x;
        win_y[0]    = y;
        points_held = 1;
      end
      1: begin
        if (last) begin
          seg_a = plain_cmd(CMD_LINE, px, py, 1'b1);
        end else begin
          n           = 0;
          win_x[1]    = x;
          win_y[1]    = y;
          points_held = 2;
        end
      end
      2: begin
        // The opening segment leaves the first point along its own chord.
        seg_a = curve_cmd(win_x[1], win_y[1], win_x[0], win_y[0],
                          win_x[1] - win_x[0], win_y[1] - win_y[0], END_TAU_DIV,
                          x - win_x[0], y - win_y[0], TAU_DIV, 1'b0);
        if (last) begin
          seg_b = curve_cmd(x, y, win_x[1], win_y[1],
                            x - win_x[0], y - win_y[0], TAU_DIV,
                            x - win_x[1], y - win_y[1], END_TAU_DIV, 1'b1);
          n     = 2;
        end else begin
          win_x[2]    = x;
          win_y[2]    = y;
          points_held = 3;
        end
      end
      default: begin
        seg_a = curve_cmd(win_x[2], win_y[2], win_x[1], win_y[1],
                          win_x[2] - win_x[0], win_y[2] - win_y[0], TAU_DIV,
                          x - win_x[1], y - win_y[1], TAU_DIV, 1'b0);
        if (last) begin
          seg_b = curve_cmd(x, y, win_x[2], win_y[2],
                            x - win_x[1], y - win_y[1], TAU_DIV,
                            x - win_x[2], y - win_y[2], END_TAU_DIV, 1'b1);
          n     = 2;
        end else begin
          win_x[0] = win_x[1];
          win_y[0] = win_y[1];
          win_x[1] = win_x[2];
          win_y[1] = win_y[2];
          win_x[2] = x;
          win_y[2] = y;
        end
      end
    endcase
    if (last) points_held = 0;
    return n;
  endfunction

  function automatic point_row_t pred_row(input coord_t x, input coord_t y, input logic last);
    point_row_t r;
    r = '{x, y, last, 1'b0, 1'b0, res_t'(0)};
    return r;
  endfunction

  function automatic point_row_t typed_row(input coord_t x, input coord_t y, input logic last,
                                           input res_t cmd);
    point_row_t r;
    r = '{x, y, last, 1'b1, 1'b1, cmd};
    return r;
  endfunction

  // A middle point that completes nothing yet.
  function automatic point_row_t silent_row(input coord_t x, input coord_t y);
    point_row_t r;
    r = '{x, y, 1'b0, 1'b1, 1'b0, res_t'(0)};
    return r;
  endfunction

  function automatic string cmd_text(input res_t c);
    return $sformatf("cmd=%0d c1=(%0d,%0d) c2=(%0d,%0d) end=(%0d,%0d) last=%0b",
                     c.command, c.ctrl1_x, c.ctrl1_y, c.ctrl2_x, c.ctrl2_y,
                     c.end_x, c.end_y, c.path_end);
  endfunction

  // Coordinate styles: 0 small walk, 1 full range, other values corners and edges mixed with random values.
  function automatic coord_t pick_coord(input int style, input coord_t prev);
    case (style)
      0: return clamp_coord(longint'(prev) + longint'($urandom_range(0, 8192)) - 4096);
      1: return coord_t'($urandom());
      default: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return coord_t'(0);
          3:       return coord_t'(-1);
          default: return coord_t'($urandom());
        endcase
      end
    endcase
  endfunction

  // Present one point, wait for it to be taken, then record what it should produce.
  task automatic send_row(input point_row_t row);
    int   gap;
    int   n;
    res_t seg_a, seg_b;
    gap = sender_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_point_x    <= row.x;
    in_point_y    <= row.y;
    in_stroke_end <= row.last;
    do @(posedge clk); while (in_stall);
    n = trace_point(row.x, row.y, row.last, seg_a, seg_b);
    if (row.typed) begin
      if (row.has_cmd) path_cmd_q.push_back(row.cmd);
    end else begin
      if (n > 0) path_cmd_q.push_back(seg_a);
      if (n > 1) path_cmd_q.push_back(seg_b);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (path_cmd_q.size() != 0);
  endtask

  // The last item of a phase may produce nothing, so allow the pipeline to empty too.
  task automatic write_smoothing(input smooth_t value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_smoothing <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    smooth_q14 = value;
  endtask

  // Whole strokes of random length and content.
  task automatic run_strokes(input int count);
    int     sent, len, style, k, r;
    coord_t x, y;
    sent = 0;
    while (sent < count) begin
      r             = $urandom_range(0, 99);
      len           = (r < 10) ? 1 : (r < 20) ? 2 : (r < 30) ? 3 : $urandom_range(4, 12);
      r             = $urandom_range(0, 9);
      style         = (r < 6) ? 0 : (r < 8) ? 1 : 2;
      sender_calm   = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) wait_drained();
      x = coord_t'($urandom());
      y = coord_t'($urandom());
      for (k = 0; k < len; k++) begin
        x = pick_coord(style, x);
        y = pick_coord(style, y);
        send_row(pred_row(x, y, k == len - 1));
        sent++;
      end
    end
  endtask

  // Result side: random stall per item, compare with the oldest expected command.
  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{command: cmd_t'(out_command), ctrl1_x: out_ctrl1_x, ctrl1_y: out_ctrl1_y,
                ctrl2_x: out_ctrl2_x, ctrl2_y: out_ctrl2_y, end_x: out_end_x,
                end_y: out_end_y, path_end: out_path_end};
        if (path_cmd_q.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("result %0d with nothing expected: %s", result_count, cmd_text(got));
          mismatch_count++;
        end else begin
          want = path_cmd_q.pop_front();
          if (got !== want) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("result %0d mismatch, expected %s", result_count, cmd_text(want));
              $display("  actual   %s", cmd_text(got));
            end
            mismatch_count++;
          end
        end
        result_count++;
        stall_left = receiver_calm ? 0 : $urandom_range(0, 16);
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_stroke_points_to_bezier_segments_top: FAIL");
    $finish;
  end

  initial begin
    point_row_t dir_rows [DIRECTED_ROWS];
    smooth_t    settings [6];
    int         i;
    smooth_q14  = Q14_ONE;
    points_held = 0;
    for (i = 0; i < 3; i++) begin
      win_x[i] = 0;
      win_y[i] = 0;
    end

    // Directed strokes, run at the reset smoothing of 1.0.
    dir_rows = '{
      // Single-point strokes at opposite corners.
      typed_row(COORD_MIN, COORD_MAX, 1'b1, plain_cmd(CMD_MOVE, COORD_MIN, COORD_MAX, 1'b1)),
      typed_row(COORD_MAX, COORD_MIN, 1'b1, plain_cmd(CMD_MOVE, COORD_MAX, COORD_MIN, 1'b1)),
      // Two-point strokes give a move and a line.
      typed_row(0, 0, 1'b0, plain_cmd(CMD_MOVE, 0, 0, 1'b0)),
      typed_row(COORD_MAX, COORD_MAX, 1'b1, plain_cmd(CMD_LINE, COORD_MAX, COORD_MAX, 1'b1)),
      typed_row(-1, -1, 1'b0, plain_cmd(CMD_MOVE, -1, -1, 1'b0)),
      typed_row(COORD_MIN, COORD_MIN, 1'b1, plain_cmd(CMD_LINE, COORD_MIN, COORD_MIN, 1'b1)),
      // Three-point stroke: the last point flushes two curves.
      typed_row(0, 0, 1'b0, plain_cmd(CMD_MOVE, 0, 0, 1'b0)),
      silent_row(256, 512),
      pred_row(1024, -256, 1'b1),
      // Full-scale zigzag drives the control points toward the range limits.
      typed_row(COORD_MIN, COORD_MIN, 1'b0, plain_cmd(CMD_MOVE, COORD_MIN, COORD_MIN, 1'b0)),
      silent_row(COORD_MAX, COORD_MAX),
      pred_row(COORD_MIN, COORD_MIN, 1'b0),
      pred_row(COORD_MAX, COORD_MAX, 1'b0),
      pred_row(COORD_MIN, COORD_MAX, 1'b1),
      // Coordinates in multiples of three give exact negative halves, rounded away from zero.
      typed_row(0, 0, 1'b0, plain_cmd(CMD_MOVE, 0, 0, 1'b0)),
      silent_row(3, -3),
      pred_row(6, -9, 1'b0),
      pred_row(-3, 3, 1'b0),
      pred_row(-12, 15, 1'b0),
      pred_row(9, 9, 1'b1)
    };
    settings = '{16'hFFFF, 16'h0000, 16'h0001, 16'hC000,
                 smooth_t'($urandom()), smooth_t'($urandom())};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) send_row(dir_rows[i]);
    run_strokes(ITEMS_PER_PHASE - DIRECTED_ROWS);

    // Each smoothing setting gets a phase of random strokes.
    for (i = 0; i < 6; i++) begin
      write_smoothing(settings[i]);
      run_strokes(ITEMS_PER_PHASE);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && path_cmd_q.size() == 0) begin
      $display("tb_stroke_points_to_bezier_segments_top: PASS");
    end else begin
      $display("tb_stroke_points_to_bezier_segments_top: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/spbs_pkg.sv
rtl/spbs_offset_lane.sv
rtl/stroke_points_to_bezier_segments_top.sv
sim/tb_stroke_points_to_bezier_segments_top.sv
